// ===== sv/mshc_pkg.sv =====
// package for the multiply-shift hash collision check unit
// holds table sizing, register indexes, state encoding and controller/datapath structs
// no dependencies
`default_nettype none

package mshc_pkg;

    // hash table sizing
    localparam int TABLE_DEPTH = 4096;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int NEED_W      = $clog2(TABLE_DEPTH + 1);

    // run tag kept with each slot; a slot is used when its tag equals the current run tag
    localparam int            EPOCH_W   = 8;
    localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
    localparam logic [EPOCH_W-1:0] EPOCH_LAST  = {EPOCH_W{1'b1}};
    localparam logic [EPOCH_W-1:0] EPOCH_NONE  = '0;

    // slot memory word: tag over value
    localparam int DATA_W = 64;
    localparam int MEM_W  = EPOCH_W + DATA_W;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;
    localparam int SHIFT_W    = 6;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HASH_MULT = 2'd0,
        CFG_OCC_MASK  = 2'd1,
        CFG_IDX_SHIFT = 2'd2
    } t_cfg_idx;

    localparam logic [SHIFT_W-1:0] SHIFT_RESET = SHIFT_W'(63);

    // controller states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MUL,
        S_ADD,
        S_SHIFT,
        S_READ,
        S_CHECK
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic mul_en;
        logic add_en;
        logic shift_en;
        logic rd_en;
        logic check_en;
        logic clr_en;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic last_item;
        logic epoch_wrap;
        logic clr_done;
    } t_dp_sts;

endpackage

`default_nettype wire

// ===== sv/multiply_shift_hash_collision_check_unit.sv =====
// a request steps through accept, multiply, add, shift, table read and check; the result strobe
// is registered from the check of a run's last request; a new request is taken only in idle
// after every 255th run the slot tags are swept: all 4096 slots are cleared with busy high
// reset: synchronous, active low; the unit then sweeps the slot table (all 4096 slots, busy high)
// results are a one-cycle strobe; the receiver cannot stall
// top level: joins mshc_ctrl and mshc_datapath, uses mshc_pkg
`default_nettype none

module multiply_shift_hash_collision_check_unit (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic [63:0]                     i_key_board,
    input  wire logic [63:0]                     i_expected_value,
    input  wire logic                            i_last_item,
    input  wire logic                            i_cfg_we,
    input  wire logic [mshc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [mshc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                                 o_done,
    output logic                                 o_collided,
    output logic [mshc_pkg::NEED_W-1:0]          o_needed_size
);

    import mshc_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    // sequencing
    mshc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    // hashing, slot table and result
    mshc_datapath u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_key_board      (i_key_board),
        .i_expected_value (i_expected_value),
        .i_last_item      (i_last_item),
        .o_done           (o_done),
        .o_collided       (o_collided),
        .o_needed_size    (o_needed_size)
    );

endmodule

`default_nettype wire

// ===== sv/mshc_ram.sv =====
// generic single write port, single read port ram with registered read data
// no dependencies
`default_nettype none

module mshc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== sv/mshc_ctrl.sv =====
// controller state machine for the hash collision check unit
// depends on mshc_pkg; drives the command struct of mshc_datapath
`default_nettype none

module mshc_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire mshc_pkg::t_dp_sts i_sts,
    output mshc_pkg::t_dp_cmd     o_cmd,
    output logic                  o_busy
);

    import mshc_pkg::*;

    t_state r_state;
    t_state n_state;

    // state register, reset starts with a clearing pass over the slot tags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_en = 1'b1;
                if (i_sts.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul_en = 1'b1;
                n_state      = S_ADD;
            end
            S_ADD: begin
                o_cmd.add_en = 1'b1;
                n_state      = S_SHIFT;
            end
            S_SHIFT: begin
                o_cmd.shift_en = 1'b1;
                n_state        = S_READ;
            end
            S_READ: begin
                o_cmd.rd_en = 1'b1;
                n_state     = S_CHECK;
            end
            S_CHECK: begin
                o_cmd.check_en = 1'b1;
                if (i_sts.last_item && i_sts.epoch_wrap) begin
                    n_state = S_CLEAR;
                end else begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

`default_nettype wire

// ===== sv/mshc_datapath.sv =====
// datapath: config registers, split 64-bit multiply, shifter, slot table and result
// depends on mshc_pkg and mshc_ram; sequenced by mshc_ctrl
`default_nettype none

module mshc_datapath (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire mshc_pkg::t_dp_cmd            i_cmd,
    output mshc_pkg::t_dp_sts                 o_sts,
    input  wire logic                         i_cfg_we,
    input  wire logic [mshc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [mshc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic [63:0]                  i_key_board,
    input  wire logic [63:0]                  i_expected_value,
    input  wire logic                         i_last_item,
    output logic                              o_done,
    output logic                              o_collided,
    output logic [mshc_pkg::NEED_W-1:0]       o_needed_size
);

    import mshc_pkg::*;

    // configuration
    logic [63:0]        r_hash_mult;
    logic [63:0]        r_occ_mask;
    logic [SHIFT_W-1:0] r_idx_shift;

    // request registers
    logic [63:0] r_key;
    logic [63:0] r_value;
    logic        r_last;

    // multiply partial products and product
    logic [63:0] r_pp0;
    logic [31:0] r_pp1;
    logic [31:0] r_pp2;
    logic [63:0] r_prod;
    logic [63:0] n_pp0;
    logic [31:0] n_pp1;
    logic [31:0] n_pp2;
    logic [63:0] n_prod;
    logic [63:0] masked_key;

    // slot index
    logic [63:0]      shifted;
    logic [IDX_W-1:0] r_idx;
    logic             r_ovf;

    // run state
    logic [IDX_W-1:0]   r_largest;
    logic [IDX_W-1:0]   n_largest;
    logic               r_failed;
    logic               n_failed;
    logic [EPOCH_W-1:0] r_epoch;
    logic [IDX_W-1:0]   r_clr_addr;

    // result
    logic              r_done;
    logic              r_collided;
    logic [NEED_W-1:0] r_need;

    // memory
    logic [MEM_W-1:0]   rdata;
    logic [EPOCH_W-1:0] rd_tag;
    logic [DATA_W-1:0]  rd_value;
    logic               slot_hit;
    logic               slot_wr;
    logic               fail_now;
    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    logic [MEM_W-1:0]   mem_wdata;
    logic               clr_done;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash_mult <= '0;
            r_occ_mask  <= '0;
            r_idx_shift <= SHIFT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_HASH_MULT: r_hash_mult <= i_cfg_data;
                CFG_OCC_MASK:  r_occ_mask  <= i_cfg_data;
                CFG_IDX_SHIFT: r_idx_shift <= i_cfg_data[SHIFT_W-1:0];
                default: ;
            endcase
        end
    end

    // capture request
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key   <= i_key_board;
            r_value <= i_expected_value;
            r_last  <= i_last_item;
        end
    end

    // three 32x32 partial products, only the low 64 bits of the product are kept
    assign masked_key = r_key & r_occ_mask;
    assign n_pp0 = masked_key[31:0] * r_hash_mult[31:0];
    assign n_pp1 = 32'(masked_key[31:0] * r_hash_mult[63:32]);
    assign n_pp2 = 32'(masked_key[63:32] * r_hash_mult[31:0]);
    assign n_prod = r_pp0 + {r_pp1 + r_pp2, 32'b0};

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_pp0 <= n_pp0;
            r_pp1 <= n_pp1;
            r_pp2 <= n_pp2;
        end
        if (i_cmd.add_en) begin
            r_prod <= n_prod;
        end
    end

    // shift by index_shift plus one, flag an index beyond the table
    assign shifted = (r_prod >> r_idx_shift) >> 1;

    always_ff @(posedge i_clk) begin
        if (i_cmd.shift_en) begin
            r_idx <= shifted[IDX_W-1:0];
            r_ovf <= (shifted >= 64'(TABLE_DEPTH));
        end
    end

    // slot check against the tag of the current run
    assign rd_tag   = rdata[MEM_W-1:DATA_W];
    assign rd_value = rdata[DATA_W-1:0];
    assign slot_hit = (rd_tag == r_epoch);
    assign slot_wr  = !r_failed && !r_ovf && !slot_hit;
    assign fail_now = r_failed || r_ovf || (slot_hit && (rd_value != r_value));

    always_comb begin
        n_largest = r_largest;
        if (!r_failed && !r_ovf && (r_idx > r_largest)) begin
            n_largest = r_idx;
        end
        n_failed = fail_now;
    end

    // run state, cleared at the end of every run
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_largest <= '0;
            r_failed  <= 1'b0;
        end else if (i_cmd.check_en) begin
            if (r_last) begin
                r_largest <= '0;
                r_failed  <= 1'b0;
            end else begin
                r_largest <= n_largest;
                r_failed  <= n_failed;
            end
        end
    end

    // run tag advances each run; on wrap the clearing pass restarts it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_epoch <= EPOCH_FIRST;
        end else if (i_cmd.clr_en && clr_done) begin
            r_epoch <= EPOCH_FIRST;
        end else if (i_cmd.check_en && r_last && (r_epoch != EPOCH_LAST)) begin
            r_epoch <= r_epoch + EPOCH_W'(1);
        end
    end

    // clearing pass address
    assign clr_done = (r_clr_addr == IDX_W'(TABLE_DEPTH - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_en) begin
            if (clr_done) begin
                r_clr_addr <= '0;
            end else begin
                r_clr_addr <= r_clr_addr + IDX_W'(1);
            end
        end
    end

    // result register, one-cycle strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.check_en && r_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.check_en && r_last) begin
            r_collided <= n_failed;
            r_need     <= n_failed ? '0 : (NEED_W'(n_largest) + NEED_W'(1));
        end
    end

    // slot memory write port shared by clearing pass and slot fill
    assign mem_we    = i_cmd.clr_en || (i_cmd.check_en && slot_wr);
    assign mem_waddr = i_cmd.clr_en ? r_clr_addr : r_idx;
    assign mem_wdata = i_cmd.clr_en ? {EPOCH_NONE, {DATA_W{1'b0}}} : {r_epoch, r_value};

    mshc_ram #(
        .WIDTH (MEM_W),
        .DEPTH (TABLE_DEPTH)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (i_cmd.rd_en),
        .i_raddr (r_idx),
        .o_rdata (rdata)
    );

    // status to controller
    assign o_sts.last_item  = r_last;
    assign o_sts.epoch_wrap = (r_epoch == EPOCH_LAST);
    assign o_sts.clr_done   = clr_done;

    assign o_done        = r_done;
    assign o_collided    = r_collided;
    assign o_needed_size = r_need;

`ifndef ASSERT_OFF
    // a result only follows the check of a last request
    a_done_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(i_cmd.check_en && r_last))
        else $error("result strobe without a finished run");

    // a collided run reports no size
    a_collided_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && r_collided) |-> (r_need == '0))
        else $error("collided result carries a size");

    // clearing pass and slot check never share the write port
    a_clr_vs_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.clr_en && i_cmd.check_en))
        else $error("clearing pass overlaps a slot check");

    // the run tag never takes the value of a cleared slot
    a_epoch_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_epoch != EPOCH_NONE)
        else $error("run tag equals cleared tag");
`endif

endmodule

`default_nettype wire
